// ----- hdl/adsr_pkg.sv -----
// Shared types, codes and constants of the ADSR envelope generator.
`default_nettype none

package adsr_pkg;

  localparam int unsigned LevelW = 25;
  localparam int unsigned CoefW  = 24;
  localparam int unsigned ProdW  = LevelW + CoefW;
  localparam int unsigned FracW  = 24;

  localparam logic [LevelW-1:0] QOne        = LevelW'(25'd16777216);
  localparam logic [LevelW-1:0] AttackSnap  = LevelW'(25'd16760438);
  localparam logic [LevelW-1:0] DecaySnap   = LevelW'(25'd16777);
  localparam logic [LevelW-1:0] ReleaseSnap = LevelW'(25'd167);

  localparam logic [CoefW-1:0]  AttackCoefRst   = CoefW'(24'd16000000);
  localparam logic [CoefW-1:0]  DecayCoefRst    = CoefW'(24'd16700000);
  localparam logic [CoefW-1:0]  ReleaseCoefRst  = CoefW'(24'd16700000);
  localparam logic [LevelW-1:0] SustainLevelRst = LevelW'(25'd9227469);

  typedef enum logic [2:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_ATTACK  = 3'd1,
    STAGE_DECAY   = 3'd2,
    STAGE_SUSTAIN = 3'd3,
    STAGE_RELEASE = 3'd4
  } stage_e;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2,
    REQ_RESET    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_ATTACK_COEF   = 2'd0,
    REG_DECAY_COEF    = 2'd1,
    REG_RELEASE_COEF  = 2'd2,
    REG_SUSTAIN_LEVEL = 2'd3
  } reg_e;

  typedef struct packed {
    logic [CoefW-1:0]  attack_coef;
    logic [CoefW-1:0]  decay_coef;
    logic [CoefW-1:0]  release_coef;
    logic [LevelW-1:0] sustain_level;
  } cfg_t;

  typedef struct packed {
    stage_e            stage;
    logic [LevelW-1:0] level;
  } env_res_t;

endpackage

`default_nettype wire

// ----- hdl/adsr_step.sv -----
// Next-state logic of the envelope: one pole step, snaps and request decode.
`default_nettype none

module adsr_step (
  input  adsr_pkg::stage_e                stage_i,
  input  logic [adsr_pkg::LevelW-1:0]     level_i,
  input  adsr_pkg::req_e                  req_i,
  input  logic                            retrig_i,
  input  adsr_pkg::cfg_t                  cfg_i,
  output adsr_pkg::env_res_t              res_o
);
  import adsr_pkg::*;

  logic [LevelW-1:0] sustain;
  logic [LevelW-1:0] target;
  logic [CoefW-1:0]  coef;
  logic              at_or_above;
  logic [LevelW-1:0] span;
  logic [ProdW-1:0]  prod;
  logic [LevelW-1:0] step_dn;
  logic [LevelW-1:0] step_up;
  logic [LevelW-1:0] stepped;
  logic [LevelW-1:0] sus_dist;
  env_res_t          tick_res;

  assign sustain = (cfg_i.sustain_level > QOne) ? QOne : cfg_i.sustain_level;

  // Pick target and coefficient for the current stage, then share one multiplier.
  always_comb begin
    case (stage_i)
      STAGE_ATTACK: begin
        target = QOne;
        coef   = cfg_i.attack_coef;
      end
      STAGE_DECAY: begin
        target = sustain;
        coef   = cfg_i.decay_coef;
      end
      default: begin
        target = '0;
        coef   = cfg_i.release_coef;
      end
    endcase
  end

  assign at_or_above = (level_i >= target);
  assign span        = at_or_above ? (level_i - target) : (target - level_i);
  assign prod        = ProdW'(coef) * ProdW'(span);

  // Floor on the signed product: truncate above target, round magnitude up below.
  assign step_dn = prod[ProdW-1:FracW];
  assign step_up = prod[ProdW-1:FracW] + LevelW'(|prod[FracW-1:0]);
  assign stepped = at_or_above ? (target + step_dn) : (target - step_up);
  assign sus_dist = (stepped >= sustain) ? (stepped - sustain) : (sustain - stepped);

  always_comb begin
    tick_res.stage = stage_i;
    tick_res.level = stepped;
    unique case (stage_i)
      STAGE_ATTACK: begin
        if (stepped > AttackSnap) begin
          tick_res.level = QOne;
          tick_res.stage = STAGE_DECAY;
        end
      end
      STAGE_DECAY: begin
        if (sus_dist <= DecaySnap) begin
          tick_res.level = sustain;
          tick_res.stage = STAGE_SUSTAIN;
        end
      end
      STAGE_SUSTAIN: begin
        tick_res.level = sustain;
      end
      STAGE_RELEASE: begin
        if (stepped <= ReleaseSnap) begin
          tick_res.level = '0;
          tick_res.stage = STAGE_IDLE;
        end
      end
      default: begin
        tick_res.level = '0;
        tick_res.stage = STAGE_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.stage = stage_i;
    res_o.level = level_i;
    unique case (req_i)
      REQ_TICK: begin
        res_o = tick_res;
      end
      REQ_NOTE_ON: begin
        if (retrig_i || (stage_i == STAGE_IDLE)) begin
          res_o.stage = STAGE_ATTACK;
        end
      end
      REQ_NOTE_OFF: begin
        if (stage_i != STAGE_IDLE) begin
          res_o.stage = STAGE_RELEASE;
        end
      end
      default: begin
        res_o.stage = STAGE_IDLE;
        res_o.level = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/adsr_skid.sv -----
// Output register with a one-entry skid stage for envelope results.
`default_nettype none

module adsr_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  adsr_pkg::env_res_t  data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output adsr_pkg::env_res_t  data_o
);
  import adsr_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  env_res_t out_q, out_d;
  env_res_t skid_q, skid_d;
  logic     out_free;

  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;
  assign out_free = !out_valid_q || ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      // Drain the skid entry first; no push can arrive while it is full.
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = data_i;
        out_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ----- hdl/adsr_envelope_generator.sv -----
// Top level of the exponential ADSR envelope generator.
//
// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: req_type; tuser: retrigger
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: level, stage
// cfg       | in  | cfg_we_i (no wait)          | cfg_addr_i, cfg_wdata_i
//
// Each transfer on s_axis yields exactly one transfer on m_axis. The envelope
// state is updated at the accepting edge by one multiply-add and its snap
// compares, so a new request can be taken every cycle while s_axis_tready is
// high. A stall on m_axis is absorbed by the output register plus a one-entry
// skid stage, and s_axis_tready drops only when both are full. Reset gives
// stage idle, level zero and the documented register defaults.
`default_nettype none

module adsr_envelope_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [adsr_pkg::LevelW-1:0]   cfg_wdata_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [1:0] req_type, [7:2] zero
  input  logic [0:0]                    s_axis_tuser,  // [0] retrigger
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata   // [24:0] level, [27:25] stage, [31:28] zero
);
  import adsr_pkg::*;

  cfg_t              cfg_q, cfg_d;
  stage_e            stage_q;
  logic [LevelW-1:0] level_q;
  env_res_t          next_res;
  env_res_t          out_res;
  logic              accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Register writes: coefficients keep the low 24 bits of the write data.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_ATTACK_COEF:   cfg_d.attack_coef   = cfg_wdata_i[CoefW-1:0];
        REG_DECAY_COEF:    cfg_d.decay_coef    = cfg_wdata_i[CoefW-1:0];
        REG_RELEASE_COEF:  cfg_d.release_coef  = cfg_wdata_i[CoefW-1:0];
        REG_SUSTAIN_LEVEL: cfg_d.sustain_level = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef   <= AttackCoefRst;
      cfg_q.decay_coef    <= DecayCoefRst;
      cfg_q.release_coef  <= ReleaseCoefRst;
      cfg_q.sustain_level <= SustainLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  adsr_step u_step (
    .stage_i  (stage_q),
    .level_i  (level_q),
    .req_i    (req_e'(s_axis_tdata[1:0])),
    .retrig_i (s_axis_tuser[0]),
    .cfg_i    (cfg_q),
    .res_o    (next_res)
  );

  // Advance the envelope state on every accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= STAGE_IDLE;
      level_q <= '0;
    end else if (accept) begin
      stage_q <= next_res.stage;
      level_q <= next_res.level;
    end
  end

  adsr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (next_res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res.stage, out_res.level};

endmodule

`default_nettype wire

// ----- dv/adsr_envelope_generator_test.sv -----
// Self-checking testbench of the ADSR envelope generator: random stream traffic, predictor.
`default_nettype none

module adsr_envelope_generator_test;
  import adsr_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    req_e kind;
    logic retrig;
  } env_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_addr_i = '0;
  logic [LevelW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;   // [1:0] req_type, [7:2] zero
  logic [0:0]        s_axis_tuser = '0;   // [0] retrigger
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [24:0] level, [27:25] stage, [31:28] zero

  adsr_envelope_generator u_top (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // Requests waiting to be driven, and envelope results still owed by the block.
  env_req_t    req_queue[$];
  env_res_t    owed_env_q[$];
  int unsigned n_pushed = 0;
  int unsigned n_results = 0;
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  int unsigned src_gap_pct = 22;
  int unsigned sink_stall_pct = 22;
  bit          req_taken = 1'b0;

  // Predictor state and its copy of the registers.
  stage_e            pred_stage = STAGE_IDLE;
  logic [LevelW-1:0] pred_level = '0;
  logic [CoefW-1:0]  cfg_attack = AttackCoefRst;
  logic [CoefW-1:0]  cfg_decay = DecayCoefRst;
  logic [CoefW-1:0]  cfg_release = ReleaseCoefRst;
  logic [LevelW-1:0] cfg_sustain = SustainLevelRst;

  // One pole step toward tgt; floor of the signed product, so round the
  // magnitude up when the level lies below the target.
  function automatic logic [LevelW-1:0] pole_step(input logic [LevelW-1:0] lvl,
                                                  input logic [LevelW-1:0] tgt,
                                                  input logic [CoefW-1:0] coef);
    logic [ProdW:0] mag;
    if (lvl >= tgt) begin
      mag = coef * (lvl - tgt);
      return tgt + LevelW'(mag >> FracW);
    end
    mag = coef * (tgt - lvl) + (2**FracW - 1);
    return tgt - LevelW'(mag >> FracW);
  endfunction

  function automatic env_res_t advance_envelope(input req_e kind, input logic retrig);
    logic [LevelW-1:0] sus;
    logic [LevelW-1:0] gap;
    env_res_t          res;
    sus = (cfg_sustain > QOne) ? QOne : cfg_sustain;
    case (kind)
      REQ_TICK: begin
        case (pred_stage)
          STAGE_ATTACK: begin
            pred_level = pole_step(pred_level, QOne, cfg_attack);
            if (pred_level > AttackSnap) begin
              pred_level = QOne;
              pred_stage = STAGE_DECAY;
            end
          end
          STAGE_DECAY: begin
            pred_level = pole_step(pred_level, sus, cfg_decay);
            gap = (pred_level >= sus) ? pred_level - sus : sus - pred_level;
            if (gap <= DecaySnap) begin
              pred_level = sus;
              pred_stage = STAGE_SUSTAIN;
            end
          end
          STAGE_SUSTAIN: pred_level = sus;
          STAGE_RELEASE: begin
            pred_level = pole_step(pred_level, '0, cfg_release);
            if (pred_level <= ReleaseSnap) begin
              pred_level = '0;
              pred_stage = STAGE_IDLE;
            end
          end
          default: begin
            pred_stage = STAGE_IDLE;
            pred_level = '0;
          end
        endcase
      end
      REQ_NOTE_ON: if (retrig || pred_stage == STAGE_IDLE) pred_stage = STAGE_ATTACK;
      REQ_NOTE_OFF: if (pred_stage != STAGE_IDLE) pred_stage = STAGE_RELEASE;
      default: begin
        pred_stage = STAGE_IDLE;
        pred_level = '0;
      end
    endcase
    res.stage = pred_stage;
    res.level = pred_level;
    return res;
  endfunction

  // Driver: change inputs on the falling edge only.
  always @(negedge clk_i) begin : drive_req
    env_req_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_taken) begin
        req_taken = 1'b0;
        if (req_queue.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          nxt = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, nxt.kind};
          s_axis_tuser <= nxt.retrig;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: sample on the rising edge, predict on each request transfer and
  // check each result transfer against the oldest owed result.
  always @(posedge clk_i) begin : watch_env
    env_res_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("adsr_envelope_generator regression: fail");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_addr_i))
          REG_ATTACK_COEF:  cfg_attack = cfg_wdata_i[CoefW-1:0];
          REG_DECAY_COEF:   cfg_decay = cfg_wdata_i[CoefW-1:0];
          REG_RELEASE_COEF: cfg_release = cfg_wdata_i[CoefW-1:0];
          default:          cfg_sustain = cfg_wdata_i;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_env_q.push_back(advance_envelope(req_e'(s_axis_tdata[1:0]), s_axis_tuser[0]));
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (owed_env_q.size() == 0) begin
          $error("result transfer with no result owed: tdata %h", m_axis_tdata);
          n_fail++;
        end else begin
          want = owed_env_q.pop_front();
          if (m_axis_tdata[24:0] !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, m_axis_tdata[24:0]);
            n_fail++;
          end
          if (m_axis_tdata[27:25] !== want.stage) begin
            $error("stage: expected %0d, got %0d", want.stage, m_axis_tdata[27:25]);
            n_fail++;
          end
        end
      end
    end
  end

  task automatic push_req(input req_e kind, input logic retrig);
    req_queue.push_back('{kind: kind, retrig: retrig});
    n_pushed++;
  endtask

  // Hold until every queued request has gone through and its result is back.
  task automatic drain();
    while (req_queue.size() != 0 || n_results < n_pushed) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [LevelW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_env(input logic [LevelW-1:0] a, input logic [LevelW-1:0] d,
                         input logic [LevelW-1:0] r, input logic [LevelW-1:0] s);
    drain();
    write_reg(REG_ATTACK_COEF, a);
    write_reg(REG_DECAY_COEF, d);
    write_reg(REG_RELEASE_COEF, r);
    write_reg(REG_SUSTAIN_LEVEL, s);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Coefficient in [lo, hi] with a random spare top bit, which the block must drop.
  function automatic logic [LevelW-1:0] rand_coef(input int unsigned lo, input int unsigned hi);
    return {1'($urandom_range(1)), CoefW'($urandom_range(hi, lo))};
  endfunction

  // Mostly whole notes (on, hold, off, tail) with random content; the rest noise.
  task automatic fill_notes(input int unsigned count);
    int unsigned stop_at;
    stop_at = n_pushed + count;
    while (n_pushed < stop_at) begin
      if ($urandom_range(99) < 20) begin
        push_req(req_e'(2'($urandom_range(3))), 1'($urandom_range(1)));
      end else begin
        push_req(REQ_NOTE_ON, 1'($urandom_range(1)));
        repeat ($urandom_range(80)) begin
          if ($urandom_range(39) == 0) push_req(REQ_NOTE_ON, 1'($urandom_range(1)));
          else push_req(REQ_TICK, 1'($urandom_range(1)));
        end
        push_req(REQ_NOTE_OFF, 1'($urandom_range(1)));
        repeat ($urandom_range(60)) push_req(REQ_TICK, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : run_stimulus
    logic [LevelW-1:0] sus;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle behaviour, note on from idle, attack and release, note off from
    // idle and attack, retrigger both ways, reset request, all at the reset settings.
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_NOTE_OFF, 1'b1);
    push_req(REQ_RESET, 1'b1);
    push_req(REQ_NOTE_ON, 1'b0);
    push_req(REQ_TICK, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_TICK, 1'b1);
    push_req(REQ_NOTE_ON, 1'b0);
    push_req(REQ_NOTE_ON, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_NOTE_OFF, 1'b0);
    push_req(REQ_TICK, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_NOTE_ON, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_RESET, 1'b0);
    push_req(REQ_TICK, 1'b1);

    // Zero coefficients jump to the target in one tick; sustain above one clamps.
    set_env('0, '0, '0, '1);
    push_req(REQ_NOTE_ON, 1'b0);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_TICK, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_NOTE_OFF, 1'b1);
    push_req(REQ_TICK, 1'b0);
    push_req(REQ_TICK, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      src_gap_pct = 22;
      sink_stall_pct = 22;
      case (ph)
        0: set_env('1, '1, '1, '0);   // slowest poles, sustain at zero
        1: begin
          // fast poles, and a long stretch without any idling
          sus = LevelW'($urandom_range(QOne));
          set_env(rand_coef(0, 4000000), rand_coef(0, 4000000), rand_coef(0, 4000000), sus);
          src_gap_pct = 0;
          sink_stall_pct = 0;
        end
        2: set_env(rand_coef(2000000, 15000000), rand_coef(2000000, 15000000),
                   rand_coef(2000000, 15000000), QOne);
        3: begin
          sus = LevelW'(QOne + $urandom_range(2**LevelW - 1 - QOne, 1));
          set_env(rand_coef(2000000, 15000000), rand_coef(2000000, 15000000),
                  rand_coef(2000000, 15000000), sus);
        end
        default: begin
          sus = LevelW'($urandom_range(QOne));
          set_env(rand_coef(2000000, 15000000), rand_coef(2000000, 15000000),
                  rand_coef(2000000, 15000000), sus);
        end
      endcase
      if (ph == 3) begin
        // stop sending half way and let every result come back first
        fill_notes(75);
        drain();
        fill_notes(75);
      end else begin
        fill_notes(ph == 0 ? 100 : 150);
      end
    end

    drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (n_fail == 0 && owed_env_q.size() == 0) begin
      $display("adsr_envelope_generator regression: pass");
    end else begin
      $display("adsr_envelope_generator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
